FILE: rtl/expression_tokenizer_assert.svh
// Assertion helpers shared by the tokenizer RTL.
// All checks are sampled on the rising edge of clock and are off while reset is high.
`ifndef EXPRESSION_TOKENIZER_ASSERT_SVH
`define EXPRESSION_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETOK_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETOK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/etok_pkg.sv
package etok_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] text_char;
      logic       has_char;
      logic       starts_token;
      logic       closes_token;
      logic       bad_char;
      logic       last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2
   } scan_mode_type;

   localparam logic [3:0] KIND_IDENT      = 4'd0;
   localparam logic [3:0] KIND_NUMBER     = 4'd1;
   localparam logic [3:0] KIND_OPERATOR   = 4'd2;
   localparam logic [3:0] KIND_LPAREN     = 4'd3;
   localparam logic [3:0] KIND_RPAREN     = 4'd4;
   localparam logic [3:0] KIND_LBRACKET   = 4'd5;
   localparam logic [3:0] KIND_RBRACKET   = 4'd6;
   localparam logic [3:0] KIND_TERMINATOR = 4'd7;
   localparam logic [3:0] KIND_DELIMITER  = 4'd8;
   localparam logic [3:0] KIND_ASSIGN     = 4'd9;
   localparam logic [3:0] KIND_EOF        = 4'd10;

   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_CARET     = 8'h5E;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_POINT     = 8'h2E;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // Returns a valid flag in the top bit and the token kind below it.
   function automatic logic [4:0] symbol_kind(input logic [7:0] c);
      logic [4:0] result;
      case (c)
         CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_CARET:
            result = {1'b1, KIND_OPERATOR};
         CHAR_LPAREN:    result = {1'b1, KIND_LPAREN};
         CHAR_RPAREN:    result = {1'b1, KIND_RPAREN};
         CHAR_LBRACKET:  result = {1'b1, KIND_LBRACKET};
         CHAR_RBRACKET:  result = {1'b1, KIND_RBRACKET};
         CHAR_SEMICOLON: result = {1'b1, KIND_TERMINATOR};
         CHAR_COMMA:     result = {1'b1, KIND_DELIMITER};
         CHAR_EQUALS:    result = {1'b1, KIND_ASSIGN};
         default:        result = {1'b0, KIND_IDENT};
      endcase
      return result;
   endfunction

endpackage

FILE: rtl/expression_tokenizer.sv
// Character-stream tokenizer for arithmetic expressions. Each input word carries one ASCII
// character or an end-of-text mark, and is turned in the cycle it is accepted into zero,
// one or two result words that enter a three-entry output queue. One input word is taken
// per cycle while the queue holds at most one result; a word other than white space that
// closes a running identifier or number yields two results, so the single output port
// falls behind on a long run of such words and req_stall holds the input back. req_stall
// comes from a register and never depends on rsp_stall in the same cycle.
`include "expression_tokenizer_assert.svh"

module expression_tokenizer
   import etok_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   scan_mode_type mode_ff, mode_in;
   logic          point_ff, point_in;
   rsp_type       queue_ff [3];
   rsp_type       queue_in [3];
   logic [1:0]    count_ff, count_in;

   logic          accept;
   logic          pop;
   logic          has_close;
   logic          has_main;
   rsp_type       close_word;
   rsp_type       main_word;
   rsp_type       first_word;
   rsp_type       second_word;
   logic [1:0]    produced;
   logic [1:0]    base;

   logic [7:0]    c;
   logic          letter;
   logic          digit;
   logic          space;
   logic [4:0]    symbol;
   logic          continues;

   assign c      = req_data.ch;
   assign letter = is_letter(c);
   assign digit  = is_digit(c);
   assign space  = is_space(c);
   assign symbol = symbol_kind(c);

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = count_ff[1];
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = queue_ff[0];

   // The character extends the running token rather than ending it.
   always_comb begin
      case (mode_ff)
         MODE_IDENT:  continues = !req_data.is_end && (letter || digit);
         MODE_NUMBER: continues = !req_data.is_end && (digit || (c == CHAR_POINT && !point_ff));
         default:     continues = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      mode_in  = mode_ff;
      point_in = point_ff;
      if (accept) begin
         if (req_data.is_end) begin
            mode_in  = MODE_IDLE;
            point_in = 1'b0;
         end else if (continues) begin
            if (mode_ff == MODE_NUMBER && c == CHAR_POINT) begin
               point_in = 1'b1;
            end
         end else begin
            if (mode_ff == MODE_NUMBER) begin
               point_in = 1'b0;
            end
            if (letter) begin
               mode_in = MODE_IDENT;
            end else if (digit) begin
               mode_in  = MODE_NUMBER;
               point_in = 1'b0;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
      end
   end

   // Result words for the word at the input.
   always_comb begin
      close_word = '0;
      close_word.kind = (mode_ff == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
      close_word.closes_token = 1'b1;
      has_close = (mode_ff == MODE_IDENT || mode_ff == MODE_NUMBER) && !continues;

      main_word = '0;
      has_main  = 1'b1;
      if (req_data.is_end) begin
         main_word.kind = KIND_EOF;
         main_word.starts_token = 1'b1;
         main_word.closes_token = 1'b1;
      end else if (continues) begin
         main_word.kind = (mode_ff == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
         main_word.text_char = c;
         main_word.has_char = 1'b1;
      end else if (space) begin
         has_main = 1'b0;
      end else if (letter || digit) begin
         main_word.kind = letter ? KIND_IDENT : KIND_NUMBER;
         main_word.text_char = c;
         main_word.has_char = 1'b1;
         main_word.starts_token = 1'b1;
      end else if (symbol[4]) begin
         main_word.kind = symbol[3:0];
         main_word.text_char = c;
         main_word.has_char = 1'b1;
         main_word.starts_token = 1'b1;
         main_word.closes_token = 1'b1;
      end else begin
         main_word.text_char = c;
         main_word.bad_char = 1'b1;
      end

      produced = {1'b0, has_close} + {1'b0, has_main};
      if (has_close) begin
         first_word = close_word;
      end else begin
         first_word = main_word;
      end
      second_word = main_word;
      first_word.last_of_run = !(has_close && has_main);
      second_word.last_of_run = 1'b1;
   end

   // Output queue: the head drains, the rest shifts down, new words land behind.
   always_comb begin
      base = count_ff - {1'b0, pop};
      for (int i = 0; i < 3; i++) begin
         if (pop && i < 2) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (accept && produced != 2'd0 && base == 2'(i)) begin
            queue_in[i] = first_word;
         end
         if (accept && produced == 2'd2 && base + 2'd1 == 2'(i)) begin
            queue_in[i] = second_word;
         end
      end
      count_in = base + (accept ? produced : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         point_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         point_ff <= point_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   `ETOK_ASSERT_SAME(a_run_complete, rsp_valid && !rsp_data.last_of_run, count_ff >= 2'd2, "head word is not last of its run but its partner is missing")
   `ETOK_ASSERT_NEXT(a_end_to_idle, accept && req_data.is_end, mode_ff == MODE_IDLE && !point_ff, "end of text did not return the scanner to idle")
   `ETOK_ASSERT_NEXT(a_bad_to_idle, accept && has_main && main_word.bad_char, mode_ff == MODE_IDLE, "bad character did not return the scanner to idle")
   `ETOK_ASSERT_NEXT(a_close_follows, accept && has_close && has_main, count_ff >= 2'd2, "close marker queued without the word that follows it")

endmodule
